/* rtl/dome_shutter_safety_supervisor_core_defines.svh */
// Assertion macros shared by the dome shutter supervisor RTL.
// Each macro expects signals named clk and rst in the using module.
`ifndef DOME_SHUTTER_SAFETY_SUPERVISOR_CORE_DEFINES_SVH
`define DOME_SHUTTER_SAFETY_SUPERVISOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define DSSS_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define DSSS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/dsss_pkg.sv */
// Shared types and codes for the dome shutter safety supervisor.
// No dependencies; imported by every module of the block.
`default_nettype none

package dsss_pkg;

  localparam int unsigned TIMER_BITS_DEF = 16;
  localparam int unsigned CFG_DATA_W     = 16;
  localparam int unsigned CFG_INDEX_W    = 4;
  localparam int unsigned S_TDATA_W      = 16;
  localparam int unsigned M_TDATA_W      = 24;

  // Register indexes and reset values
  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_MOVE    = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_ENVIRON = 4'd1;
  localparam logic [CFG_DATA_W-1:0]  MOVE_TIMEOUT_RST    = 16'd300;
  localparam logic [CFG_DATA_W-1:0]  ENVIRON_TIMEOUT_RST = 16'd600;

  // Event kinds
  localparam logic [3:0] CMD_TICK      = 4'd0;
  localparam logic [3:0] CMD_STATUS    = 4'd1;
  localparam logic [3:0] CMD_ENVIRON   = 4'd2;
  localparam logic [3:0] CMD_TARGET    = 4'd3;
  localparam logic [3:0] CMD_QUIT      = 4'd4;
  localparam logic [3:0] CMD_LOCK      = 4'd5;
  localparam logic [3:0] CMD_MAN_OPEN  = 4'd6;
  localparam logic [3:0] CMD_MAN_CLOSE = 4'd7;
  localparam logic [3:0] CMD_MAN_STOP  = 4'd8;

  // Shutter status values and bits
  localparam logic [2:0] ST_NONE   = 3'd0;
  localparam logic [2:0] ST_OPEN   = 3'd1;
  localparam logic [2:0] ST_CLOSED = 3'd2;
  localparam int unsigned ST_OPEN_BIT   = 0;
  localparam int unsigned ST_CLOSED_BIT = 1;

  // Drive commands
  localparam logic [1:0] DRV_NONE  = 2'd0;
  localparam logic [1:0] DRV_OPEN  = 2'd1;
  localparam logic [1:0] DRV_CLOSE = 2'd2;
  localparam logic [1:0] DRV_STOP  = 2'd3;

  // Completion status
  localparam logic [1:0] CS_GOOD   = 2'd0;
  localparam logic [1:0] CS_CANCEL = 2'd1;
  localparam logic [1:0] CS_WAIT   = 2'd2;
  localparam logic [1:0] CS_CRIT   = 2'd3;

  // Open transition events
  localparam logic [1:0] OE_NONE     = 2'd0;
  localparam logic [1:0] OE_OPENED   = 2'd1;
  localparam logic [1:0] OE_UNOPENED = 2'd2;

  typedef struct packed {
    logic [3:0] cmd;
    logic [2:0] status_bits;
    logic       weather_ok;
    logic       night;
    logic       critical;
    logic       auto_mode;
    logic       lock_on;
    logic [7:0] msg_tag;
  } item_t;

  typedef struct packed {
    logic [1:0] drive_cmd;
    logic       complete_valid;
    logic [1:0] complete_status;
    logic [7:0] complete_tag;
    logic [1:0] open_event;
    logic       open_allowed;
    logic       timed_out;
  } result_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] move_timeout_ticks;
    logic [CFG_DATA_W-1:0] environ_timeout_ticks;
  } cfg_t;

endpackage

`default_nettype wire

/* rtl/dsss_in_reg.sv */
// Input register: holds one accepted item until the engine takes it.
// Depends on dsss_pkg for the item type.
`default_nettype none

module dsss_in_reg import dsss_pkg::*; (
  input  wire   clk,
  input  wire   rst,
  input  wire   in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  wire   take,
  output logic  q_valid,
  output item_t q_item
);

  // Free when empty or when the held item leaves this cycle
  assign in_ready = !q_valid || take;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_ready) begin
      q_valid <= in_valid;
    end
  end

  // Capture payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      q_item <= in_item;
    end
  end

endmodule

`default_nettype wire

/* rtl/dsss_engine.sv */
// Supervisor state and the per-item update logic (one item per cycle while step is set).
// Depends on dsss_pkg for types and codes.
`default_nettype none

module dsss_engine import dsss_pkg::*; #(
  parameter int unsigned TIMER_BITS = TIMER_BITS_DEF
) (
  input  wire     clk,
  input  wire     rst,
  input  wire     step,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t res
);

  `include "dome_shutter_safety_supervisor_core_defines.svh"

  localparam int unsigned CMP_W = (TIMER_BITS > CFG_DATA_W) ? TIMER_BITS : CFG_DATA_W;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

  logic [2:0]            cur_status, cur_status_next;
  logic [2:0]            goal_status, goal_status_next;
  logic                  weather_good, weather_good_next;
  logic                  sun_good, sun_good_next;
  logic                  locked, locked_next;
  logic                  pending_valid, pending_valid_next;
  logic [7:0]            pending_tag, pending_tag_next;
  logic                  move_active, move_active_next;
  logic [TIMER_BITS-1:0] move_count, move_count_next;
  logic                  env_active, env_active_next;
  logic [TIMER_BITS-1:0] env_count, env_count_next;

  logic [TIMER_BITS-1:0] move_inc, env_inc;
  logic                  move_hit, env_hit;

  // Saturating tick increments and expiry compares
  always_comb begin
    move_inc = (move_count == TIMER_MAX) ? move_count : move_count + 1'b1;
    env_inc  = (env_count == TIMER_MAX) ? env_count : env_count + 1'b1;
    move_hit = (CMP_W'(move_inc) >= CMP_W'(cfg.move_timeout_ticks)) || (move_inc == TIMER_MAX);
    env_hit  = (CMP_W'(env_inc) >= CMP_W'(cfg.environ_timeout_ticks)) || (env_inc == TIMER_MAX);
  end

  logic       wu_req, wu_w, wu_s;
  logic       msg, go_pend;
  logic [1:0] ret_status;

  // Apply one event to the state, in the order the events are defined
  always_comb begin
    cur_status_next    = cur_status;
    goal_status_next   = goal_status;
    weather_good_next  = weather_good;
    sun_good_next      = sun_good;
    locked_next        = locked;
    pending_valid_next = pending_valid;
    pending_tag_next   = pending_tag;
    move_active_next   = move_active;
    move_count_next    = move_count;
    env_active_next    = env_active;
    env_count_next     = env_count;
    res        = '0;
    wu_req     = 1'b0;
    wu_w       = 1'b0;
    wu_s       = 1'b0;
    msg        = 1'b0;
    go_pend    = 1'b0;
    ret_status = CS_GOOD;

    unique case (item.cmd)
      CMD_TICK: begin
        // Move timer first: fault completes pending and forces a close
        if (move_active && move_hit) begin
          res.timed_out = 1'b1;
          if (pending_valid_next) begin
            res.complete_valid    = 1'b1;
            res.complete_status   = CS_CRIT;
            res.complete_tag      = pending_tag;
            pending_valid_next    = 1'b0;
          end
          res.drive_cmd    = DRV_CLOSE;
          goal_status_next = ST_CLOSED;
          move_count_next  = '0;
          move_active_next = (cur_status != ST_CLOSED);
        end else if (move_active) begin
          move_count_next = move_inc;
        end
        // Then the environment watchdog
        if (env_active && env_hit) begin
          env_active_next = 1'b0;
          env_count_next  = '0;
          wu_req          = 1'b1;
        end else if (env_active) begin
          env_count_next = env_inc;
        end
      end
      CMD_STATUS: begin
        if (item.status_bits != cur_status) begin
          if (item.status_bits[ST_OPEN_BIT] && !cur_status[ST_OPEN_BIT]) begin
            res.open_event = OE_OPENED;
          end else if (!item.status_bits[ST_OPEN_BIT] &&
                       (cur_status[ST_OPEN_BIT] || cur_status == ST_NONE)) begin
            res.open_event = OE_UNOPENED;
          end
          if (item.status_bits == goal_status) begin
            move_active_next = 1'b0;
            move_count_next  = '0;
            if (pending_valid) begin
              res.complete_valid  = 1'b1;
              res.complete_status = CS_GOOD;
              res.complete_tag    = pending_tag;
              pending_valid_next  = 1'b0;
            end
          end
          cur_status_next = item.status_bits;
        end
      end
      CMD_ENVIRON: begin
        env_active_next = 1'b1;
        env_count_next  = '0;
        wu_req          = 1'b1;
        wu_w            = item.weather_ok;
        wu_s            = item.night;
        msg             = 1'b1;
      end
      CMD_TARGET: begin
        msg = 1'b1;
        if (item.critical) begin
          if (!cur_status[ST_CLOSED_BIT]) begin
            if (pending_valid) begin
              res.complete_valid  = 1'b1;
              res.complete_status = CS_CANCEL;
              res.complete_tag    = pending_tag;
            end
            res.drive_cmd    = DRV_CLOSE;
            goal_status_next = ST_CLOSED;
            move_count_next  = '0;
            move_active_next = (cur_status != ST_CLOSED);
            go_pend          = 1'b1;
          end
        end else if (item.auto_mode && !cur_status[ST_OPEN_BIT]) begin
          if (!weather_good || !sun_good || pending_valid) begin
            ret_status = CS_WAIT;
          end else begin
            res.drive_cmd    = DRV_OPEN;
            goal_status_next = ST_OPEN;
            move_count_next  = '0;
            move_active_next = (cur_status != ST_OPEN);
            go_pend          = 1'b1;
          end
        end
      end
      CMD_QUIT: begin
        msg = 1'b1;
        if (item.auto_mode && !cur_status[ST_CLOSED_BIT]) begin
          if (pending_valid) begin
            res.complete_valid  = 1'b1;
            res.complete_status = CS_CANCEL;
            res.complete_tag    = pending_tag;
          end
          res.drive_cmd    = DRV_CLOSE;
          goal_status_next = ST_CLOSED;
          move_count_next  = '0;
          move_active_next = (cur_status != ST_CLOSED);
          go_pend          = 1'b1;
        end
      end
      CMD_LOCK: begin
        locked_next = item.lock_on;
      end
      CMD_MAN_OPEN: begin
        if (!locked && weather_good && sun_good) begin
          res.drive_cmd    = DRV_OPEN;
          goal_status_next = ST_OPEN;
          move_count_next  = '0;
          move_active_next = (cur_status != ST_OPEN);
        end
      end
      CMD_MAN_CLOSE: begin
        if (!locked) begin
          res.drive_cmd    = DRV_CLOSE;
          goal_status_next = ST_CLOSED;
          move_count_next  = '0;
          move_active_next = (cur_status != ST_CLOSED);
        end
      end
      CMD_MAN_STOP: begin
        res.drive_cmd    = DRV_STOP;
        move_active_next = 1'b0;
        move_count_next  = '0;
        goal_status_next = ST_NONE;
      end
      default: begin
      end
    endcase

    // Weather update from an environment message or a watchdog expiry
    if (wu_req && !(wu_w == weather_good_next && wu_s == sun_good_next)) begin
      weather_good_next = wu_w;
      sun_good_next     = wu_s;
      if (!(wu_w && wu_s) && !cur_status_next[ST_CLOSED_BIT]) begin
        if (pending_valid_next) begin
          res.complete_valid  = 1'b1;
          res.complete_status = CS_CANCEL;
          res.complete_tag    = pending_tag;
          pending_valid_next  = 1'b0;
        end
        res.drive_cmd    = DRV_CLOSE;
        goal_status_next = ST_CLOSED;
        move_count_next  = '0;
        move_active_next = (cur_status_next != ST_CLOSED);
        go_pend          = 1'b1;
      end
    end

    // Park the message or answer it at once
    if (msg) begin
      if (go_pend) begin
        pending_valid_next = 1'b1;
        pending_tag_next   = item.msg_tag;
      end else begin
        res.complete_valid  = 1'b1;
        res.complete_status = ret_status;
        res.complete_tag    = item.msg_tag;
      end
    end

    res.open_allowed = !locked_next && weather_good_next && sun_good_next;
  end

  // Advance control state on each item
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_status    <= ST_NONE;
      goal_status   <= ST_NONE;
      weather_good  <= 1'b0;
      sun_good      <= 1'b0;
      locked        <= 1'b0;
      pending_valid <= 1'b0;
      move_active   <= 1'b0;
      move_count    <= '0;
      env_active    <= 1'b0;
      env_count     <= '0;
    end else if (step) begin
      cur_status    <= cur_status_next;
      goal_status   <= goal_status_next;
      weather_good  <= weather_good_next;
      sun_good      <= sun_good_next;
      locked        <= locked_next;
      pending_valid <= pending_valid_next;
      move_active   <= move_active_next;
      move_count    <= move_count_next;
      env_active    <= env_active_next;
      env_count     <= env_count_next;
    end
  end

  // Pending tag is meaningful only while pending_valid is set
  always_ff @(posedge clk) begin
    if (step) begin
      pending_tag <= pending_tag_next;
    end
  end

  `DSSS_ASSERT_NOW(a_move_has_goal, move_active, goal_status != ST_NONE, "move timer without goal")
  `DSSS_ASSERT_NOW(a_timeout_closes, res.timed_out, res.drive_cmd == DRV_CLOSE, "timeout without close")
  `DSSS_ASSERT_NEXT(a_lock_only_by_cmd, step && item.cmd != CMD_LOCK, locked == $past(locked), "lock changed")

endmodule

`default_nettype wire

/* rtl/dsss_out_reg.sv */
// Result register: holds one result item until the sink takes it.
// Depends on dsss_pkg for the result type.
`default_nettype none

module dsss_out_reg import dsss_pkg::*; (
  input  wire     clk,
  input  wire     rst,
  input  wire     load,
  input  result_t d,
  output logic    free,
  output logic    out_valid,
  input  wire     out_ready,
  output result_t q
);

  // Slot can take a new result when empty or being drained
  assign free = !out_valid || out_ready;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= load;
    end
  end

  // Hold payload while stalled
  always_ff @(posedge clk) begin
    if (load) begin
      q <= d;
    end
  end

endmodule

`default_nettype wire

/* rtl/dome_shutter_safety_supervisor_core.sv */
// Channel   Handshake                Payload
// s_*       s_tvalid / s_tready      s_tuser event kind, s_tdata message fields
// m_*       m_tvalid / m_tready      m_tdata one result per item
// cfg_*     cfg_valid / cfg_ready    cfg_index register, cfg_data value
//
// One result per item; an item goes input register -> result register, and one
// item per cycle is sustained while m_tready is high and the output does not stall.
// The state update in dsss_engine is combinational between the two registers.
// Reset is synchronous and clears both registers, all flags and both timers.
// A stall on m_tready holds the result; the input register takes one more item.
// Top level of the dome shutter supervisor; uses dsss_pkg and its submodules.
`default_nettype none

module dome_shutter_safety_supervisor_core import dsss_pkg::*; #(
  parameter int unsigned TIMER_BITS = TIMER_BITS_DEF
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    s_tvalid,
  output logic                   s_tready,
  // [2:0] status_bits, [3] weather_ok, [4] night, [5] critical, [6] auto_mode,
  // [7] lock_on, [15:8] msg_tag
  input  wire  [S_TDATA_W-1:0]   s_tdata,
  // [3:0] cmd
  input  wire  [3:0]             s_tuser,
  output logic                   m_tvalid,
  input  wire                    m_tready,
  // [1:0] drive_cmd, [2] complete_valid, [4:3] complete_status,
  // [12:5] complete_tag, [14:13] open_event, [15] open_allowed, [16] timed_out,
  // [23:17] zero
  output logic [M_TDATA_W-1:0]   m_tdata,
  input  wire                    cfg_valid,
  output logic                   cfg_ready,
  input  wire  [CFG_INDEX_W-1:0] cfg_index,
  input  wire  [CFG_DATA_W-1:0]  cfg_data
);

  `include "dome_shutter_safety_supervisor_core_defines.svh"

  item_t   in_item, q_item;
  logic    q_valid, take, out_free;
  result_t res, out_res;
  cfg_t    cfg;

  // Unpack the input item
  always_comb begin
    in_item.cmd         = s_tuser;
    in_item.status_bits = s_tdata[2:0];
    in_item.weather_ok  = s_tdata[3];
    in_item.night       = s_tdata[4];
    in_item.critical    = s_tdata[5];
    in_item.auto_mode   = s_tdata[6];
    in_item.lock_on     = s_tdata[7];
    in_item.msg_tag     = s_tdata[15:8];
  end

  // Configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.move_timeout_ticks    <= MOVE_TIMEOUT_RST;
      cfg.environ_timeout_ticks <= ENVIRON_TIMEOUT_RST;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_IDX_MOVE) begin
        cfg.move_timeout_ticks <= cfg_data;
      end else if (cfg_index == CFG_IDX_ENVIRON) begin
        cfg.environ_timeout_ticks <= cfg_data;
      end
    end
  end

  // Advance an item when the result slot can take its result
  assign take = q_valid && out_free;

  dsss_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_item  (in_item),
    .take     (take),
    .q_valid  (q_valid),
    .q_item   (q_item)
  );

  dsss_engine #(
    .TIMER_BITS (TIMER_BITS)
  ) u_engine (
    .clk  (clk),
    .rst  (rst),
    .step (take),
    .item (q_item),
    .cfg  (cfg),
    .res  (res)
  );

  dsss_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (take),
    .d         (res),
    .free      (out_free),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .q         (out_res)
  );

  // Pack the result item
  assign m_tdata = {7'd0, out_res.timed_out, out_res.open_allowed, out_res.open_event,
                    out_res.complete_tag, out_res.complete_status,
                    out_res.complete_valid, out_res.drive_cmd};

  `DSSS_ASSERT_NOW(a_take_needs_slot, take, !m_tvalid || m_tready, "result overwritten")
  `DSSS_ASSERT_NEXT(a_take_gives_result, take, m_tvalid, "result lost")
  `DSSS_ASSERT_NEXT(a_no_result_from_nothing, !take && m_tvalid && m_tready, !m_tvalid, "result repeated")

endmodule

`default_nettype wire
